>>> design/modexp_pkg.sv
package modexp_pkg;

  localparam int FIELD_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

  // what the shared unit adds in on a set scan bit
  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_MUL,
    SEL_SQR
  } sel_t;

  typedef struct packed {
    logic mod_zero;
    logic expo_zero;
    logic expo_lsb;
  } modexp_stat_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic clear;
    logic step;
    sel_t sel;
    logic scan_load;
    logic res_wr;
    logic base_wr;
    logic expo_shift;
    logic done;
  } modexp_ctrl_t;

endpackage

>>> design/modexp_step.sv
module modexp_step #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         clear,
  input  logic         step,
  input  logic [W-1:0] addend,
  input  logic         bit_in,
  input  logic [W-1:0] modulus,
  output logic [W-1:0] acc_next
);

  localparam int TW = W + 3;

  logic [W-1:0]  acc;
  logic [TW-1:0] t;
  logic [TW-1:0] d1;
  logic [TW-1:0] d2;

  // t = 2*acc + addend stays below 3*modulus, so at most two subtractions
  assign t  = {2'b00, acc, 1'b0} + (bit_in ? TW'(addend) : '0);
  assign d1 = t - TW'(modulus);
  assign d2 = t - {2'b00, modulus, 1'b0};

  always_comb begin
    if (!d2[TW-1]) begin
      acc_next = d2[W-1:0];
    end else if (!d1[TW-1]) begin
      acc_next = d1[W-1:0];
    end else begin
      acc_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (step) begin
      acc <= acc_next;
    end
  end

endmodule

>>> design/modexp_ctrl.sv
module modexp_ctrl #(
  parameter int W = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  modexp_pkg::modexp_stat_t stat,
  output modexp_pkg::modexp_ctrl_t ctl
);

  import modexp_pkg::*;

  localparam int CW = $clog2(W);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic          cnt_last;
  logic          stepping;

  assign cnt_last = (cnt == CW'(W - 1));
  assign stepping = (state == ST_REDUCE) || (state == ST_MUL) || (state == ST_SQR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (!stepping || cnt_last) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_START;
      end
      ST_START: begin
        state_next = stat.mod_zero ? ST_DONE : ST_REDUCE;
      end
      ST_REDUCE: begin
        if (cnt_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.expo_zero) begin
          state_next = ST_DONE;
        end else if (stat.expo_lsb) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_SQR;
        end
      end
      ST_MUL: begin
        if (cnt_last) state_next = ST_SQR;
      end
      ST_SQR: begin
        if (cnt_last) state_next = ST_CHECK;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.sel  = SEL_REDUCE;
    ctl.busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        ctl.load  = start;
        ctl.clear = start;
      end
      ST_START: begin
      end
      ST_REDUCE: begin
        ctl.step    = 1'b1;
        ctl.sel     = SEL_REDUCE;
        ctl.base_wr = cnt_last;
      end
      ST_CHECK: begin
        ctl.scan_load = !stat.expo_zero;
        ctl.clear     = !stat.expo_zero;
      end
      ST_MUL: begin
        ctl.step      = 1'b1;
        ctl.sel       = SEL_MUL;
        ctl.res_wr    = cnt_last;
        ctl.scan_load = cnt_last;
        ctl.clear     = cnt_last;
      end
      ST_SQR: begin
        ctl.step       = 1'b1;
        ctl.sel        = SEL_SQR;
        ctl.base_wr    = cnt_last;
        ctl.expo_shift = cnt_last;
      end
      ST_DONE: begin
        ctl.done = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/modular_exponentiation.sv
// Right-to-left square and multiply: power_result = base_value ** exponent mod modulus.
// A transfer is taken when start is high and busy is low; busy then stays high until the
// result has gone out. The result is shown for one cycle with done high and is not held,
// so the receiver must take it then. One add-and-reduce unit does all the arithmetic,
// one bit per cycle: first it reduces the base, then for each exponent bit up to the
// highest set one it does a check, a multiply when the bit is set, and a squaring.
// A zero modulus gives mod_error with a zero result. A zero exponent returns 1 even
// for a modulus of one. Operands are taken at their low OPERAND_WIDTH bits.
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [modexp_pkg::FIELD_W-1:0] base_value,
  input  logic [modexp_pkg::FIELD_W-1:0] exponent,
  input  logic [modexp_pkg::FIELD_W-1:0] modulus,
  output logic                           done,
  output logic [modexp_pkg::FIELD_W-1:0] power_result,
  output logic                           mod_error
);

  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH;

  modexp_ctrl_t ctl;
  modexp_stat_t stat;

  logic [W-1:0] base_r;
  logic [W-1:0] expo_r;
  logic [W-1:0] mod_r;
  logic [W-1:0] res_r;
  logic [W-1:0] scan_r;
  logic [W-1:0] addend;
  logic [W-1:0] acc_next;

  assign stat.mod_zero  = (mod_r == '0);
  assign stat.expo_zero = (expo_r == '0);
  assign stat.expo_lsb  = expo_r[0];

  modexp_ctrl #(
    .W(W)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctl  (ctl)
  );

  always_comb begin
    case (ctl.sel)
      SEL_MUL: addend = res_r;
      SEL_SQR: addend = base_r;
      default: addend = W'(1);
    endcase
  end

  // reduction feeds the base bits in as a shift-subtract remainder
  modexp_step #(
    .W(W)
  ) u_step (
    .clk     (clk),
    .clear   (ctl.clear),
    .step    (ctl.step),
    .addend  (addend),
    .bit_in  (scan_r[W-1]),
    .modulus (mod_r),
    .acc_next(acc_next)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      base_r <= W'(base_value);
      expo_r <= W'(exponent);
      mod_r  <= W'(modulus);
      res_r  <= W'(1);
      scan_r <= W'(base_value);
    end else begin
      if (ctl.scan_load) begin
        scan_r <= base_r;
      end else if (ctl.step) begin
        scan_r <= scan_r << 1;
      end
      if (ctl.res_wr) res_r <= acc_next;
      if (ctl.base_wr) base_r <= acc_next;
      if (ctl.expo_shift) expo_r <= expo_r >> 1;
    end
  end

  assign busy         = ctl.busy;
  assign done         = ctl.done;
  assign mod_error    = stat.mod_zero;
  assign power_result = stat.mod_zero ? '0 : FIELD_W'(res_r);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transfer");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a busy period");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && mod_error |-> power_result == '0)
    else $error("nonzero result with zero modulus");

endmodule

>>> sim/modular_exponentiation_test.sv
`timescale 1ns / 1ps

module modular_exponentiation_test;
  import modexp_pkg::*;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct {
    word_t value;
    logic  err;
  } power_answer_t;

  typedef struct {
    word_t base_v;
    word_t expo_v;
    word_t mod_v;
    bit    known;
    word_t value;
    logic  err;
  } op_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  word_t base_value = '0;
  word_t exponent = '0;
  word_t modulus = '0;
  logic  busy;
  logic  done;
  word_t power_result;
  logic  mod_error;

  power_answer_t pending_powers[$];
  op_row_t       directed_rows[$];
  int            sender_idle_pct = 0;
  int            mismatches = 0;
  int            transfers_in = 0;
  int            results_checked = 0;
  int            zero_mod_results = 0;
  int            zero_expo_items = 0;

  modular_exponentiation dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base_value(base_value),
    .exponent(exponent),
    .modulus(modulus),
    .done(done),
    .power_result(power_result),
    .mod_error(mod_error)
  );

  always #4 clk = ~clk;

  // right to left square and multiply, products held at double width
  function automatic power_answer_t power_mod(word_t b, word_t e, word_t m);
    logic [63:0]   acc;
    logic [63:0]   sq;
    power_answer_t ans;
    int            i;
    ans.value = '0;
    ans.err = 1'b1;
    if (m != 0) begin
      sq = {32'd0, b} % {32'd0, m};
      acc = 64'd1;
      for (i = 0; i < FIELD_W && (e >> i) != 0; i++) begin
        // the initial 1 only gets reduced once it is multiplied in
        if (e[i])
          acc = ((acc % {32'd0, m}) * sq) % {32'd0, m};
        sq = (sq * sq) % {32'd0, m};
      end
      ans.value = acc[FIELD_W-1:0];
      ans.err = 1'b0;
    end
    return ans;
  endfunction

  function automatic void add_row(word_t b, word_t e, word_t m, bit known, word_t v,
                                  logic er);
    op_row_t row;
    row.base_v = b;
    row.expo_v = e;
    row.mod_v = m;
    row.known = known;
    row.value = v;
    row.err = er;
    directed_rows.push_back(row);
  endfunction

  // called at a rising edge; returns at the edge where the transfer is taken
  task automatic send_item(word_t b, word_t e, word_t m, bit known, word_t v, logic er);
    power_answer_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    base_value <= b;
    exponent <= e;
    modulus <= m;
    do @(posedge clk); while (busy);
    if (known) begin
      want.value = v;
      want.err = er;
    end else begin
      want = power_mod(b, e, m);
    end
    pending_powers.push_back(want);
    transfers_in++;
    if (e == 0)
      zero_expo_items++;
  endtask

  task automatic drain_results;
    start <= 1'b0;
    while (pending_powers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random;
    word_t b;
    word_t e;
    word_t m;
    int    pick;
    b = $urandom;
    e = $urandom;
    m = $urandom;
    pick = $urandom_range(99);
    if (pick < 4)
      m = '0;
    else if (pick < 12)
      m = $urandom_range(16, 1);
    else if (pick < 20)
      m = 32'hFFFF_FFFF - $urandom_range(15, 0);
    else if (pick < 30)
      m = $urandom_range(65535, 2);
    pick = $urandom_range(99);
    if (pick < 4)
      e = '0;
    else if (pick < 10)
      e = 32'h1 << $urandom_range(31, 0);
    else if (pick < 60)
      e = e >> $urandom_range(31, 0);  // keeps most runs short
    pick = $urandom_range(99);
    if (pick < 5)
      b = '0;
    else if (pick < 10)
      b = 32'hFFFF_FFFF;
    else if (pick < 15)
      b = m;
    else if (pick < 25)
      b = $urandom_range(255, 0);
    send_item(b, e, m, 1'b0, '0, 1'b0);
  endtask

  // results cannot be held off, so every strobe is checked on the edge that ends it
  always @(posedge clk) begin
    power_answer_t want;
    if (!rst && done) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: result %h (mod_error %b) with nothing outstanding", $time,
                 power_result, mod_error);
        mismatches++;
      end else begin
        want = pending_powers.pop_front();
        results_checked++;
        if (mod_error)
          zero_mod_results++;
        if (power_result !== want.value) begin
          $display("%0t: power_result expected %h got %h", $time, want.value, power_result);
          mismatches++;
        end
        if (mod_error !== want.err) begin
          $display("%0t: mod_error expected %b got %b", $time, want.err, mod_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int n;
    add_row(32'd5, 32'd3, 32'd0, 1'b1, 32'd0, 1'b1);
    add_row(32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0, 1'b1);
    add_row(32'd7, 32'd0, 32'd1, 1'b1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0);
    add_row(32'd9, 32'd4, 32'd1, 1'b1, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'd0, 1'b0);
    add_row(32'd0, 32'd5, 32'd13, 1'b1, 32'd0, 1'b0);
    add_row(32'd100, 32'd1, 32'd7, 1'b1, 32'd2, 1'b0);
    add_row(32'd2, 32'd10, 32'd1000, 1'b1, 32'd24, 1'b0);
    add_row(32'd3, 32'd4, 32'd5, 1'b1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 1'b1, 32'd1, 1'b0);
    // minus one to an odd power
    add_row(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b0);
    // fermat on the largest 32-bit prime
    add_row(32'd2, 32'hFFFF_FFFA, 32'hFFFF_FFFB, 1'b1, 32'd1, 1'b0);
    add_row(32'hFFFF_FFFA, 32'd2, 32'hFFFF_FFFB, 1'b1, 32'd1, 1'b0);
    add_row(32'hDEAD_BEEF, 32'h8000_0000, 32'hFFFF_FFFB, 1'b0, '0, 1'b0);
    add_row(32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0, '0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAB, 1'b0, '0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h0000_0002, 1'b0, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 30;
    foreach (directed_rows[i])
      send_item(directed_rows[i].base_v, directed_rows[i].expo_v, directed_rows[i].mod_v,
                directed_rows[i].known, directed_rows[i].value, directed_rows[i].err);
    drain_results();

    for (n = 0; n < 280; n++) begin
      if (n == 95)
        sender_idle_pct = 58;
      else if (n == 190)
        sender_idle_pct = 0;
      send_random();
      if ($urandom_range(99) < 4)
        drain_results();
    end
    start <= 1'b0;

    while (pending_powers.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d transfers in, %0d results checked: %0d zero-modulus errors, %0d zero exponents",
             transfers_in, results_checked, zero_mod_results, zero_expo_items);
    if (mismatches == 0)
      $display("modular_exponentiation_test: clean");
    else
      $display("modular_exponentiation_test: errors");
    $finish;
  end

  initial begin
    #25_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("modular_exponentiation_test: errors");
    $finish;
  end

endmodule
